// ----- hdl/pqr_pkg.sv -----
package pqr_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_REPRIO = 2'd2;

	typedef enum logic [1:0] {
		K_INSERT,
		K_REMOVE,
		K_REPRIO,
		K_NOP
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_EMPTY,
		ST_FULL,
		ST_NOTFOUND
	} status_t;

endpackage

// ----- hdl/pqr_front.sv -----
module pqr_front import pqr_pkg::*; #(
	parameter int ID_BITS = 16,
	parameter int PRIORITY_BITS = 8,
	localparam int CMD_W = $bits(cmd_kind_t) + ID_BITS + PRIORITY_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               in_opcode,
	input  logic [ID_BITS-1:0]       in_id,
	input  logic [PRIORITY_BITS-1:0] in_pri,
	output logic                     cmd_valid,
	input  logic                     cmd_ready,
	output logic [CMD_W-1:0]         cmd_data
);

	logic             valid_q;
	logic [CMD_W-1:0] data_q;
	cmd_kind_t        kind;

	always_comb begin
		case (in_opcode)
			OP_INSERT: kind = K_INSERT;
			OP_REMOVE: kind = K_REMOVE;
			OP_REPRIO: kind = K_REPRIO;
			default:   kind = K_NOP;
		endcase
	end

	assign in_ready  = !valid_q || cmd_ready;
	assign cmd_valid = valid_q;
	assign cmd_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= {kind, in_id, in_pri};
		end
	end

endmodule

// ----- hdl/pqr_fifo.sv -----
module pqr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = cnt_q != CW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= in_data;
		end
	end

endmodule

// ----- hdl/pqr_back.sv -----
module pqr_back import pqr_pkg::*; #(
	parameter int CAPACITY = 128,
	parameter int ID_BITS = 16,
	parameter int PRIORITY_BITS = 8,
	localparam int CNT_W = $clog2(CAPACITY + 1),
	localparam int CMD_W = $bits(cmd_kind_t) + ID_BITS + PRIORITY_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  logic [CMD_W-1:0]         cmd_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ID_BITS-1:0]       out_id,
	output logic [PRIORITY_BITS-1:0] out_priority,
	output status_t                  out_status,
	output logic [CNT_W-1:0]         out_count
);

	typedef enum logic {
		S_IDLE,
		S_APPLY
	} state_t;

	// Sorted cell row; cell 0 holds the head.
	logic [ID_BITS-1:0]       ids_q  [CAPACITY];
	logic [PRIORITY_BITS-1:0] pris_q [CAPACITY];
	logic [CNT_W-1:0]         count_q;

	state_t                   state_q;
	logic                     found_q;
	logic [CAPACITY-1:0]      ge_q;
	logic [ID_BITS-1:0]       id_q;
	logic [PRIORITY_BITS-1:0] pri_q;
	logic                     out_valid_q;
	logic [ID_BITS-1:0]       out_id_q;
	logic [PRIORITY_BITS-1:0] out_pri_q;
	status_t                  out_st_q;
	logic [CNT_W-1:0]         out_cnt_q;

	cmd_kind_t                kind;
	logic [ID_BITS-1:0]       c_id;
	logic [PRIORITY_BITS-1:0] c_pri;
	logic                     can_issue;
	logic [CAPACITY-1:0]      match;
	logic [CAPACITY-1:0]      pre;
	logic                     found;

	logic                     pop;
	logic                     go_apply;
	logic                     load;
	logic                     we;
	logic                     ins_en;
	logic [CAPACITY-1:0]      shift_mask;
	logic [ID_BITS-1:0]       op_id;
	logic [PRIORITY_BITS-1:0] op_pri;
	logic [CNT_W-1:0]         cnt_c;
	logic [CNT_W-1:0]         cnt_n;
	logic [ID_BITS-1:0]       res_id;
	logic [PRIORITY_BITS-1:0] res_pri;
	status_t                  res_st;

	logic [ID_BITS-1:0]       n_id   [CAPACITY];
	logic [PRIORITY_BITS-1:0] n_pri  [CAPACITY];
	logic [ID_BITS-1:0]       fin_id [CAPACITY];
	logic [PRIORITY_BITS-1:0] fin_pri[CAPACITY];
	logic [CAPACITY-1:0]      bef;

	assign kind      = cmd_kind_t'(cmd_data[CMD_W-1 -: $bits(cmd_kind_t)]);
	assign c_id      = cmd_data[PRIORITY_BITS +: ID_BITS];
	assign c_pri     = cmd_data[PRIORITY_BITS-1:0];
	assign can_issue = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign out_id       = out_id_q;
	assign out_priority = out_pri_q;
	assign out_status   = out_st_q;
	assign out_count    = out_cnt_q;
	assign cmd_ready    = pop;

	// Marks every cell at or after the first live entry whose id matches.
	always_comb begin
		pre = match;
		for (int s = 1; s < CAPACITY; s = s * 2) begin
			pre = pre | (pre << s);
		end
	end
	assign found = |match;

	always_comb begin
		pop        = 1'b0;
		go_apply   = 1'b0;
		load       = 1'b0;
		we         = 1'b0;
		ins_en     = 1'b0;
		shift_mask = '0;
		op_id      = c_id;
		op_pri     = c_pri;
		cnt_c      = count_q;
		cnt_n      = count_q;
		res_id     = '0;
		res_pri    = '0;
		res_st     = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (kind)
						K_REPRIO: begin
							pop      = 1'b1;
							go_apply = 1'b1;
						end
						K_INSERT: begin
							if (can_issue) begin
								pop  = 1'b1;
								load = 1'b1;
								if (count_q == CNT_W'(CAPACITY)) begin
									res_st = ST_FULL;
								end else begin
									we     = 1'b1;
									ins_en = 1'b1;
									cnt_n  = count_q + 1'b1;
								end
							end
						end
						K_REMOVE: begin
							if (can_issue) begin
								pop  = 1'b1;
								load = 1'b1;
								if (count_q == '0) begin
									res_st = ST_EMPTY;
								end else begin
									we         = 1'b1;
									shift_mask = '1;
									cnt_c      = count_q - 1'b1;
									cnt_n      = count_q - 1'b1;
									res_id     = ids_q[0];
									res_pri    = pris_q[0];
								end
							end
						end
						default: begin
							if (can_issue) begin
								pop  = 1'b1;
								load = 1'b1;
							end
						end
					endcase
				end
			end
			S_APPLY: begin
				if (can_issue) begin
					load = 1'b1;
					if (found_q) begin
						// Close the slot of the match, then reinsert; cells
						// from the old slot on sort the new entry ahead of equals.
						we         = 1'b1;
						shift_mask = ge_q;
						ins_en     = 1'b1;
						op_id      = id_q;
						op_pri     = pri_q;
						cnt_c      = count_q - 1'b1;
					end else begin
						res_st = ST_NOTFOUND;
					end
				end
			end
			default: ;
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign match[i] = (CNT_W'(i) < count_q) && (ids_q[i] == c_id);

		if (i + 1 < CAPACITY) begin : g_shift
			assign n_id[i]  = shift_mask[i] ? ids_q[i+1]  : ids_q[i];
			assign n_pri[i] = shift_mask[i] ? pris_q[i+1] : pris_q[i];
		end else begin : g_last
			assign n_id[i]  = ids_q[i];
			assign n_pri[i] = pris_q[i];
		end

		assign bef[i] = (CNT_W'(i) < cnt_c) &&
			(shift_mask[i] ? (n_pri[i] > op_pri) : (n_pri[i] >= op_pri));

		if (i == 0) begin : g_head
			assign fin_id[i]  = (!ins_en || bef[i]) ? n_id[i]  : op_id;
			assign fin_pri[i] = (!ins_en || bef[i]) ? n_pri[i] : op_pri;
		end else begin : g_body
			assign fin_id[i]  = (!ins_en || bef[i]) ? n_id[i]  :
				(bef[i-1] ? op_id  : n_id[i-1]);
			assign fin_pri[i] = (!ins_en || bef[i]) ? n_pri[i] :
				(bef[i-1] ? op_pri : n_pri[i-1]);
		end

		always_ff @(posedge clk) begin
			if (we) begin
				ids_q[i]  <= fin_id[i];
				pris_q[i] <= fin_pri[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_id_q    <= '0;
			out_pri_q   <= '0;
			out_st_q    <= ST_OK;
			out_cnt_q   <= '0;
		end else begin
			count_q <= cnt_n;
			if (go_apply) begin
				state_q <= S_APPLY;
				found_q <= found;
			end else if (state_q == S_APPLY && load) begin
				state_q <= S_IDLE;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				out_id_q    <= res_id;
				out_pri_q   <= res_pri;
				out_st_q    <= res_st;
				out_cnt_q   <= cnt_n;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_apply) begin
			ge_q  <= pre;
			id_q  <= c_id;
			pri_q <= c_pri;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
		count_q == $past(count_q) - 1'b1))
		else $error("entry count moved by more than one");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_st == ST_EMPTY) |-> count_q == '0)
		else $error("empty status with stored entries");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_st == ST_FULL) |-> count_q == CNT_W'(CAPACITY))
		else $error("full status below capacity");

	a_apply_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && found_q) |-> ge_q != '0)
		else $error("reprioritize applied without a matched slot");

endmodule

// ----- hdl/priority_queue_with_reprioritize.sv -----
// Sorted priority queue of up to CAPACITY requests (id, priority), highest
// priority at the head and equal priorities in arrival order. Each input
// transaction carries one operation and yields exactly one result transaction
// with the removed head (zero unless a successful remove), a status of ok,
// empty, full or not found, and the entry count afterwards. The entries live
// in a row of cells that all shift and compare in parallel, so insert, remove
// and the unused opcode are handled in the idle state of the back end alone,
// while reprioritize locates the first matching id in the idle state and then
// closes its slot and reinserts it in the apply state. A front register and a
// two-entry command queue sit ahead of the cell row. Every result passes
// through the front register, the command queue and the output register of
// the back end, and a reprioritize also through the apply state. No clearing
// pass is needed after reset.
module priority_queue_with_reprioritize import pqr_pkg::*; #(
	parameter int CAPACITY = 128,
	parameter int ID_BITS = 16,
	parameter int PRIORITY_BITS = 8,
	localparam int CNT_W = $clog2(CAPACITY + 1),
	localparam int IN_W = ID_BITS + PRIORITY_BITS,
	localparam int IN_TW = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W = ID_BITS + PRIORITY_BITS + 2 + CNT_W,
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// item_id, item_priority
	input  logic [IN_TW-1:0]  s_axis_tdata,
	// opcode
	input  logic [1:0]        s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// out_id, out_priority, status, entry_count
	output logic [OUT_TW-1:0] m_axis_tdata
);

	localparam int CMD_W = $bits(cmd_kind_t) + ID_BITS + PRIORITY_BITS;

	logic                     f_valid;
	logic                     f_ready;
	logic [CMD_W-1:0]         f_data;
	logic                     q_valid;
	logic                     q_ready;
	logic [CMD_W-1:0]         q_data;
	logic [ID_BITS-1:0]       r_id;
	logic [PRIORITY_BITS-1:0] r_pri;
	status_t                  r_st;
	logic [CNT_W-1:0]         r_cnt;

	pqr_front #(
		.ID_BITS       (ID_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_opcode (s_axis_tuser),
		.in_id     (s_axis_tdata[0 +: ID_BITS]),
		.in_pri    (s_axis_tdata[ID_BITS +: PRIORITY_BITS]),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd_data  (f_data)
	);

	pqr_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	pqr_back #(
		.CAPACITY      (CAPACITY),
		.ID_BITS       (ID_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd_ready    (q_ready),
		.cmd_data     (q_data),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_id       (r_id),
		.out_priority (r_pri),
		.out_status   (r_st),
		.out_count    (r_cnt)
	);

	always_comb begin
		m_axis_tdata            = '0;
		m_axis_tdata[OUT_W-1:0] = {r_cnt, r_st, r_pri, r_id};
	end

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
	import pqr_pkg::*;

	localparam int CAPACITY = 128;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SCRIPT_LEN = 22;
	localparam logic [1:0] OP_NOP = K_NOP;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  pr;
		status_t     st;
		logic [7:0]  cnt;
	} pq_result_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] id;
		logic [7:0]  pr;
		logic        typed;
		pq_result_t  want;
	} script_row_t;

	typedef enum logic [1:0] {
		LOAD_MIX,
		LOAD_FILL,
		LOAD_DRAIN
	} load_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// item_id, item_priority
	logic [23:0] s_axis_tdata;
	// opcode
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// out_id, out_priority, status, entry_count
	logic [39:0] m_axis_tdata;

	// Shadow copy of the sorted queue contents.
	logic [15:0] queue_ids [CAPACITY];
	logic [7:0]  queue_prs [CAPACITY];
	int          queue_len;

	pq_result_t  pending [$];
	int          errors;
	int          cycles;
	bit          calm;

	// Rows with typed results can be read off directly; the rest go through the predictor.
	script_row_t script [SCRIPT_LEN] = '{
		'{OP_REMOVE, 16'h0000, 8'h00, 1'b1, '{16'h0, 8'h0, ST_EMPTY, 8'd0}},
		'{OP_REPRIO, 16'h1234, 8'h00, 1'b1, '{16'h0, 8'h0, ST_NOTFOUND, 8'd0}},
		'{OP_NOP,    16'hFFFF, 8'hFF, 1'b1, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_INSERT, 16'hFFFF, 8'hFF, 1'b1, '{16'h0, 8'h0, ST_OK, 8'd1}},
		'{OP_INSERT, 16'h0000, 8'h00, 1'b1, '{16'h0, 8'h0, ST_OK, 8'd2}},
		'{OP_INSERT, 16'h0001, 8'h80, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_INSERT, 16'h0002, 8'h80, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_INSERT, 16'h0001, 8'h10, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_INSERT, 16'hAAAA, 8'h55, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_INSERT, 16'h5555, 8'hAA, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_REPRIO, 16'h0001, 8'hFF, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_REPRIO, 16'h0002, 8'h80, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_REPRIO, 16'hFFFF, 8'h00, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_REPRIO, 16'hBEEF, 8'h05, 1'b1, '{16'h0, 8'h0, ST_NOTFOUND, 8'd7}},
		'{OP_REMOVE, 16'h0000, 8'h00, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_REMOVE, 16'h0000, 8'h00, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_REMOVE, 16'h0000, 8'h00, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_REMOVE, 16'h0000, 8'h00, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_REMOVE, 16'h0000, 8'h00, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_REMOVE, 16'h0000, 8'h00, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_REMOVE, 16'h0000, 8'h00, 1'b0, '{16'h0, 8'h0, ST_OK, 8'd0}},
		'{OP_REMOVE, 16'hFFFF, 8'hFF, 1'b1, '{16'h0, 8'h0, ST_EMPTY, 8'd0}}
	};

	priority_queue_with_reprioritize #(
		.CAPACITY(CAPACITY),
		.ID_BITS(16),
		.PRIORITY_BITS(8)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A new entry goes after every entry ranked at or above it. Below index lim a tie
	// counts as ranked above; from lim on only a strictly higher priority does.
	function automatic int slot_for(input logic [7:0] pr, input int lim);
		int pos;
		pos = 0;
		for (int j = 0; j < queue_len; j++) begin
			if (j < lim ? queue_prs[j] >= pr : queue_prs[j] > pr)
				pos++;
		end
		return pos;
	endfunction

	task automatic make_room(input int pos);
		for (int j = queue_len; j > pos; j--) begin
			queue_ids[j] = queue_ids[j-1];
			queue_prs[j] = queue_prs[j-1];
		end
	endtask

	task automatic drop_at(input int pos);
		for (int j = pos; j + 1 < queue_len; j++) begin
			queue_ids[j] = queue_ids[j+1];
			queue_prs[j] = queue_prs[j+1];
		end
	endtask

	task automatic apply_op(input logic [1:0] op, input logic [15:0] id, input logic [7:0] pr,
			output pq_result_t r);
		int pos;
		int hit;
		r.id = '0;
		r.pr = '0;
		r.st = ST_OK;
		case (op)
			OP_INSERT: begin
				if (queue_len >= CAPACITY) begin
					r.st = ST_FULL;
				end else begin
					pos = slot_for(pr, queue_len);
					make_room(pos);
					queue_ids[pos] = id;
					queue_prs[pos] = pr;
					queue_len++;
				end
			end
			OP_REMOVE: begin
				if (queue_len == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.id = queue_ids[0];
					r.pr = queue_prs[0];
					drop_at(0);
					queue_len--;
				end
			end
			OP_REPRIO: begin
				hit = -1;
				for (int j = 0; j < queue_len && hit < 0; j++) begin
					if (queue_ids[j] == id)
						hit = j;
				end
				if (hit < 0) begin
					r.st = ST_NOTFOUND;
				end else begin
					// The old position stands in for the arrival time of the moved entry.
					drop_at(hit);
					queue_len--;
					pos = slot_for(pr, hit);
					make_room(pos);
					queue_ids[pos] = id;
					queue_prs[pos] = pr;
					queue_len++;
				end
			end
			default: ;
		endcase
		r.cnt = queue_len[7:0];
	endtask

	task automatic flag(input string what, input longint got, input longint want);
		errors++;
		if (errors <= 50)
			$display("tb_top: %s got %0h expected %0h at cycle %0d", what, got, want, cycles);
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic put_item(input logic [1:0] op, input logic [15:0] id, input logic [7:0] pr,
			input logic typed, input pq_result_t want, output status_t st);
		pq_result_t r;
		if (!calm) begin
			s_axis_tvalid = 1'b0;
			while ($urandom_range(99) < 27)
				@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {pr, id};
		s_axis_tuser = op;
		do @(posedge clk); while (!s_axis_tready);
		apply_op(op, id, pr, r);
		pending.push_back(typed ? want : r);
		st = r.st;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_item(input load_mode_t mode, inout int counted, inout int full_hits,
			inout int empty_hits);
		logic [1:0]  op;
		logic [15:0] id;
		logic [7:0]  pr;
		int          k;
		status_t     st;
		k = $urandom_range(99);
		case (mode)
			LOAD_FILL:
				op = k < 88 ? OP_INSERT : k < 96 ? OP_REPRIO : k < 98 ? OP_REMOVE : OP_NOP;
			LOAD_DRAIN:
				op = k < 75 ? OP_REMOVE : k < 95 ? OP_REPRIO : k < 98 ? OP_INSERT : OP_NOP;
			default:
				op = k < 35 ? OP_INSERT : k < 70 ? OP_REMOVE : k < 97 ? OP_REPRIO : OP_NOP;
		endcase
		// Ids are often taken from the queue or a tiny pool so that duplicates and
		// successful searches are common.
		k = $urandom_range(99);
		if (queue_len > 0 && k < 50)
			id = queue_ids[$urandom_range(0, queue_len - 1)];
		else if (k < 75)
			id = 16'($urandom_range(0, 7));
		else
			id = 16'($urandom_range(0, 16'hFFFF));
		k = $urandom_range(99);
		if (k < 40)
			pr = 8'($urandom_range(0, 3));
		else if (k < 55)
			pr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		else
			pr = 8'($urandom_range(0, 255));
		put_item(op, id, pr, 1'b0, '0, st);
		if (op != OP_NOP)
			counted++;
		if (st == ST_FULL)
			full_hits++;
		if (st == ST_EMPTY)
			empty_hits++;
	endtask

	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_axis_tready = calm || ($urandom_range(99) >= 27);
		end
	end

	always @(posedge clk) begin
		pq_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending.size() == 0) begin
				flag("result with nothing pending, tdata", m_axis_tdata, 0);
			end else begin
				want = pending.pop_front();
				if (m_axis_tdata[15:0] !== want.id)
					flag("out_id", m_axis_tdata[15:0], want.id);
				if (m_axis_tdata[23:16] !== want.pr)
					flag("out_priority", m_axis_tdata[23:16], want.pr);
				if (m_axis_tdata[25:24] !== want.st)
					flag("status", m_axis_tdata[25:24], want.st);
				if (m_axis_tdata[33:26] !== want.cnt)
					flag("entry_count", m_axis_tdata[33:26], want.cnt);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		int      counted;
		int      full_hits;
		int      empty_hits;
		status_t st;
		errors = 0;
		cycles = 0;
		calm = 1'b0;
		queue_len = 0;
		counted = 0;
		full_hits = 0;
		empty_hits = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++)
			put_item(script[i].op, script[i].id, script[i].pr, script[i].typed, script[i].want, st);

		// Hold off until every outstanding result is back.
		wait_drained();

		while (counted < 60)
			random_item(LOAD_MIX, counted, full_hits, empty_hits);
		while (full_hits < 3)
			random_item(LOAD_FILL, counted, full_hits, empty_hits);
		wait_drained();
		calm = 1'b1;
		empty_hits = 0;
		while (empty_hits < 3)
			random_item(LOAD_DRAIN, counted, full_hits, empty_hits);
		calm = 1'b0;
		while (counted < 370)
			random_item(LOAD_MIX, counted, full_hits, empty_hits);

		wait_drained();
		repeat (16) @(negedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/pqr_pkg.sv
hdl/pqr_front.sv
hdl/pqr_fifo.sv
hdl/pqr_back.sv
hdl/priority_queue_with_reprioritize.sv
tb/sv/tb_top.sv
